>>> hdl/pce_pkg.sv
package pce_pkg;

	// number of ports in the i/o window, two slots (read, write) per port
	localparam int PORT_COUNT = 80;
	localparam int SLOT_COUNT = 2 * PORT_COUNT;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);

	localparam logic [7:0] PORT_LIMIT = 8'(PORT_COUNT);

	// stream codes
	localparam logic [7:0]  INIT_MARKER = 8'hF8;
	localparam logic [7:0]  SHORT_TAG   = 8'hFE;
	localparam logic [7:0]  LONG_TAG    = 8'hFF;
	localparam logic [31:0] SHORT_LIMIT = 32'h0000_FFFF;

	// longest record: marker, long tag, four delta bytes, slot, data
	localparam int REC_MAX = 8;
	localparam int LEN_W   = $clog2(REC_MAX + 1);
	localparam int PTR_W   = $clog2(REC_MAX);

	typedef struct packed {
		logic        action;
		logic [31:0] timestamp;
		logic [6:0]  port_addr;
		logic        direction;
		logic [7:0]  port_value;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
	} out_t;

	typedef struct packed {
		logic [REC_MAX-1:0][7:0] bytes;
		logic [LEN_W-1:0]        len;
	} rec_t;

endpackage

>>> hdl/port_change_trace_encoder.sv
// port change trace encoder: takes one port event per beat and turns each
// event that matters into a byte record (optional init marker 0xf8, time
// since the last record in one, three or five bytes, slot = port*2+dir, then
// the xor of changed bits or, for init, the absolute byte). an accepted event
// is registered together with its shadow ram read and resolved in the stage
// after it; a record that commits is loaded into the serializer, which then
// offers its first byte. events are taken one per cycle as long as records
// drain: an event that emits nothing sends no bytes, an emitting event holds
// the byte-wide output for its record of 3 to 8 bytes. the output serializer is
// the rate limit. the shadow bytes sit in a 160 x 8 ram with one valid flop
// per slot, so reset takes effect at once with no clearing pass, and an
// event that hits the slot written by the event just before it is served by
// forwarding from the write port.
module port_change_trace_encoder (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  pce_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output pce_pkg::out_t out_data
);

	// accept stage
	logic                       in_beat;
	logic [7:0]                 in_slot;
	logic [pce_pkg::SLOT_W-1:0] in_idx;

	// resolve stage (works on the registered ram read data)
	logic                       vld_s1;
	pce_pkg::in_t               item_s1;
	logic                       fwd_s1;
	logic [7:0]                 fwd_data_s1;
	logic                       shv_s1;

	logic [7:0]                 slot_s1;
	logic [pce_pkg::SLOT_W-1:0] idx_s1;
	logic                       inrange_s1;
	logic [7:0]                 ram_rdata;
	logic [7:0]                 shadow_cur;
	logic [7:0]                 data_s1;
	logic [31:0]                delta_s1;
	logic                       emit_s1;
	logic                       adv_s1;
	logic                       commit_s1;

	// architectural state beside the ram
	logic [31:0]                last_time_q;
	logic [pce_pkg::SLOT_COUNT-1:0] shadow_vld_q;

	pce_pkg::rec_t              rec;
	logic                       can_load;

	assign in_slot = {in_data.port_addr, in_data.direction};
	assign in_idx  = in_slot[pce_pkg::SLOT_W-1:0];
	assign in_beat = in_valid && in_ready;

	assign slot_s1    = {item_s1.port_addr, item_s1.direction};
	assign idx_s1     = slot_s1[pce_pkg::SLOT_W-1:0];
	assign inrange_s1 = ({1'b0, item_s1.port_addr} < pce_pkg::PORT_LIMIT);

	// never-written slots read as zero, a same-cycle write wins over the ram
	assign shadow_cur = fwd_s1 ? fwd_data_s1 : (shv_s1 ? ram_rdata : 8'h00);
	assign data_s1    = item_s1.action ? item_s1.port_value
	                                   : (item_s1.port_value ^ shadow_cur);
	assign delta_s1   = item_s1.timestamp - last_time_q;

	// out-of-range ports and unchanged bytes fall through without a record
	assign emit_s1   = vld_s1 && inrange_s1 && (item_s1.action || (data_s1 != 8'h00));
	assign adv_s1    = !emit_s1 || can_load;
	assign commit_s1 = emit_s1 && can_load;
	assign in_ready  = !vld_s1 || adv_s1;

	pce_ram #(
		.WIDTH (8),
		.DEPTH (pce_pkg::SLOT_COUNT)
	) u_shadow (
		.clk   (clk),
		.we    (commit_s1),
		.waddr (idx_s1),
		.wdata (item_s1.port_value),
		.re    (in_beat),
		.raddr (in_idx),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1       <= 1'b0;
			last_time_q  <= '0;
			shadow_vld_q <= '0;
		end else begin
			if (in_beat) begin
				vld_s1 <= 1'b1;
			end else if (adv_s1) begin
				vld_s1 <= 1'b0;
			end
			if (commit_s1) begin
				last_time_q          <= item_s1.timestamp;
				shadow_vld_q[idx_s1] <= 1'b1;
			end
		end
	end

	// payload of the resolve stage, with the forward from a same-slot commit
	always_ff @(posedge clk) begin
		if (in_beat) begin
			item_s1     <= in_data;
			fwd_s1      <= commit_s1 && (idx_s1 == in_idx);
			fwd_data_s1 <= item_s1.port_value;
			shv_s1      <= shadow_vld_q[in_idx];
		end
	end

	// record assembly: bytes are packed from the front, len counts them
	always_comb begin
		logic [pce_pkg::LEN_W-1:0] n;
		rec = '0;
		n   = '0;
		if (item_s1.action) begin
			rec.bytes[n[pce_pkg::PTR_W-1:0]] = pce_pkg::INIT_MARKER;
			n = n + pce_pkg::LEN_W'(1);
		end
		if (delta_s1 < {24'd0, pce_pkg::INIT_MARKER}) begin
			// short delta fits in one byte
			rec.bytes[n[pce_pkg::PTR_W-1:0]] = delta_s1[7:0];
			n = n + pce_pkg::LEN_W'(1);
		end else if (delta_s1 < pce_pkg::SHORT_LIMIT) begin
			// 16-bit delta, little-endian
			rec.bytes[n[pce_pkg::PTR_W-1:0]] = pce_pkg::SHORT_TAG;
			n = n + pce_pkg::LEN_W'(1);
			for (int i = 0; i < 2; i++) begin
				rec.bytes[n[pce_pkg::PTR_W-1:0]] = delta_s1[8*i +: 8];
				n = n + pce_pkg::LEN_W'(1);
			end
		end else begin
			// 32-bit delta, little-endian, also for exactly 0xffff
			rec.bytes[n[pce_pkg::PTR_W-1:0]] = pce_pkg::LONG_TAG;
			n = n + pce_pkg::LEN_W'(1);
			for (int i = 0; i < 4; i++) begin
				rec.bytes[n[pce_pkg::PTR_W-1:0]] = delta_s1[8*i +: 8];
				n = n + pce_pkg::LEN_W'(1);
			end
		end
		rec.bytes[n[pce_pkg::PTR_W-1:0]] = slot_s1;
		n = n + pce_pkg::LEN_W'(1);
		rec.bytes[n[pce_pkg::PTR_W-1:0]] = data_s1;
		n = n + pce_pkg::LEN_W'(1);
		rec.len = n;
	end

	// byte serializer doubles as the skid between event side and stream side
	pce_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (commit_s1),
		.rec       (rec),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

>>> hdl/pce_ram.sv
module pce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 160
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/pce_ser.sv
module pce_ser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  pce_pkg::rec_t rec,
	output logic          can_load,
	output logic          out_valid,
	input  logic          out_ready,
	output pce_pkg::out_t out_data
);

	pce_pkg::rec_t               rec_q;
	logic                        busy_q;
	logic [pce_pkg::PTR_W-1:0]   ptr_q;
	logic [pce_pkg::LEN_W-1:0]   len_m1;
	logic [pce_pkg::PTR_W-1:0]   last_idx;
	logic                        beat;
	logic                        done;

	assign len_m1   = rec_q.len - pce_pkg::LEN_W'(1);
	assign last_idx = len_m1[pce_pkg::PTR_W-1:0];
	assign beat     = busy_q && out_ready;
	assign done     = beat && (ptr_q == last_idx);
	assign can_load = !busy_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ptr_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			ptr_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (beat) begin
			ptr_q <= ptr_q + pce_pkg::PTR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec_q <= rec;
		end
	end

	assign out_valid          = busy_q;
	assign out_data.out_byte  = rec_q.bytes[ptr_q];
	assign out_data.last_byte = (ptr_q == last_idx);

endmodule

>>> hdl/pce_chk.sv
module pce_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input pce_pkg::in_t  in_data,
	input logic          out_valid,
	input logic          out_ready,
	input pce_pkg::out_t out_data
);

	logic       out_beat;
	logic [2:0] cnt_q;
	logic [7:0] prev_q;

	assign out_beat = out_valid && out_ready;

	// position within the current record and the byte before this one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			prev_q <= '0;
		end else if (out_beat) begin
			cnt_q  <= out_data.last_byte ? 3'd0 : (cnt_q + 3'd1);
			prev_q <= out_data.out_byte;
		end
	end

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input beat changed while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	a_min_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && out_data.last_byte |-> cnt_q >= 3'd2)
		else $error("record shorter than three bytes");

	a_max_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && (cnt_q == 3'd7) |-> out_data.last_byte)
		else $error("record longer than eight bytes");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && out_data.last_byte |-> {1'b0, prev_q} < 9'(pce_pkg::SLOT_COUNT))
		else $error("slot byte out of range");

endmodule

bind port_change_trace_encoder pce_chk u_pce_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
